FILE: src/slist_pkg.sv
// Package for the sorted list store: sizes, request and status codes,
// word types of both channels and the cell link types. No dependencies.
package slist_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int VAL_W      = 32;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] removed_value;
    logic [4:0]              entry_count;
    logic [1:0]              status;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                    ins_en;
    logic signed [VAL_W-1:0] key;
  } cell_cmd_t;

  // per-cell position flags, derived from the fill count
  typedef struct packed {
    logic occ;
    logic last;
  } cell_pos_t;

  // handed from a cell to its right neighbor
  typedef struct packed {
    logic                    shift;
    logic signed [VAL_W-1:0] data;
  } cell_link_t;

endpackage

FILE: src/slist_cell.sv
// One compare-and-shift cell of the sorted list row.
// Depends on slist_pkg.
module slist_cell import slist_pkg::*; (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  cell_pos_t               pos,
  input  cell_link_t              link_in,
  output cell_link_t              link_out,
  output logic                    hit,
  output logic signed [VAL_W-1:0] pop_data
);

  logic signed [VAL_W-1:0] entry;

  // this cell and everything to its right moves for the new key
  assign link_out.shift = !pos.occ || (entry >= cmd.key);
  assign link_out.data  = entry;

  assign hit      = pos.occ && (entry == cmd.key);
  assign pop_data = pos.last ? entry : '0;

  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      if (link_in.shift) begin
        entry <= link_in.data;
      end else if (link_out.shift) begin
        entry <= cmd.key;
      end
    end
  end

endmodule

FILE: src/sorted_list_insert_search_pop.sv
// Top level of the sorted list store: controller, fill count and result
// register around a row of slist_cell instances. Depends on slist_pkg.
//
// Usage:
//   Requests enter on req (req_valid/req_ready), one word per request:
//   insert, search or remove-largest, with a signed 32-bit value.
//   Every request yields exactly one response word on rsp
//   (rsp_valid/rsp_ready) carrying found, removed_value, entry_count
//   and status (ok, insert dropped on full, remove on empty).
//   rsp_valid rises in the cycle after acceptance. The row of cells
//   compares and shifts all entries in the accept cycle, so one request
//   is taken per cycle as long as the response side keeps up.
//   The response register frees in the cycle it is taken, so req_ready
//   is high whenever rsp is empty or being taken this cycle. If the
//   receiver stalls, the response holds and req_ready drops until it
//   is taken.
//   A request code of 3 is a no-op that reports the current count.
//   Synchronous reset empties the list (count to zero) and clears
//   rsp_valid; entry storage is not cleared and is never read unwritten.
module sorted_list_insert_search_pop import slist_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  rsp_t             rsp_next;

  logic req_fire;
  logic full;
  logic empty;
  logic any_hit;
  logic signed [VAL_W-1:0] last_val;

  cell_cmd_t               cmd;
  cell_pos_t               pos  [LIST_DEPTH];
  cell_link_t              link [LIST_DEPTH+1];
  logic [LIST_DEPTH-1:0]   hits;
  logic signed [VAL_W-1:0] pops [LIST_DEPTH];

  assign req_ready = !rsp_valid || rsp_ready;
  assign req_fire  = req_valid && req_ready;
  assign full      = (count == CNT_W'(LIST_DEPTH));
  assign empty     = (count == '0);

  assign cmd.ins_en = req_fire && (req.req_type == REQ_INSERT) && !full;
  assign cmd.key    = req.value;

  assign link[0].shift = 1'b0;
  assign link[0].data  = '0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    assign pos[i].occ  = (count > CNT_W'(i));
    assign pos[i].last = (count == CNT_W'(i + 1));

    slist_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos      (pos[i]),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .hit      (hits[i]),
      .pop_data (pops[i])
    );
  end

  assign any_hit = |hits;

  always_comb begin
    last_val = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      last_val = last_val | pops[i];
    end
  end

  always_comb begin
    count_next             = count;
    rsp_next.found         = 1'b0;
    rsp_next.removed_value = '0;
    rsp_next.status        = ST_OK;
    case (req.req_type)
      REQ_INSERT: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      REQ_SEARCH: begin
        rsp_next.found = any_hit;
      end
      REQ_REMOVE: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          count_next             = count - 1'b1;
          rsp_next.removed_value = last_val;
        end
      end
      default: begin
      end
    endcase
    rsp_next.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp <= rsp_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LIST_DEPTH))
    else $error("fill count beyond depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    req_fire && (req.req_type == REQ_INSERT) && full
    |=> (rsp.status == ST_FULL) && (count == $past(count)))
    else $error("insert on full store changed the count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    req_fire && (req.req_type == REQ_REMOVE) && !empty
    |=> (count == $past(count) - 1'b1) && (rsp.status == ST_OK))
    else $error("remove did not shrink the list");

  a_search_stable: assert property (@(posedge clk) disable iff (rst)
    req_fire && (req.req_type == REQ_SEARCH) |=> $stable(count))
    else $error("search changed the count");

  for (genvar i = 0; i + 1 < LIST_DEPTH; i++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      pos[i+1].occ |-> (link[i+1].data <= link[i+2].data))
      else $error("list out of order");
  end

endmodule
